/* sv/assert_macros.svh */
// Assertion macros shared by the noise turbulence RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define VNT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define VNT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/vnt_pkg.sv */
// Shared widths, register indexes and the issue record of the noise turbulence block.
`default_nettype none
package vnt_pkg;

  localparam int COORD_W    = 7;
  localparam int VAL_W      = 16;
  localparam int GRAY_W     = 8;
  localparam int GS_W       = 8;
  localparam int ZOOM_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  // Corner weights are at most 128 * 128, so 15 bits suffice.
  localparam int WT_W       = 15;
  localparam int PROD_W     = WT_W + VAL_W;
  // The weighted octave sum stays below 2^31.
  localparam int ACC_W      = 32;
  localparam int SHAMT_W    = 5;

  localparam logic [SHAMT_W-1:0] GRAY_SHIFT_BASE = 5'd9;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_LOG2 = 2'd1;

  localparam logic [GS_W-1:0]   GRID_SIZE_RST = 8'd128;
  localparam logic [ZOOM_W-1:0] ZOOM_RST      = 3'd5;

  // One table read handed from the sequencer to the multiply-accumulate pipe.
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic [ZOOM_W-1:0] shift;
    logic [WT_W-1:0]   weight;
  } mac_issue_t;

endpackage
`default_nettype wire

/* sv/value_noise_turbulence_top.sv */
// Top level of the value noise turbulence block: registers, noise table and result stage.
//
//  channel | signals                                  | carries
//  --------+------------------------------------------+----------------------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | grid_size (0), zoom_log2 (1)
//  in      | in_valid in_ready kind row col noise_value | store sample or pixel request
//  out     | out_valid out_ready gray                 | one gray level per pixel item
//
// A store item is written to the table at its accept edge.
// A pixel item holds the input through the remainder steps down to its first octave, then
// four table reads per octave bound by the single read port, and then through read data,
// product, sum, pending slot and output register.
// in_ready falls while a pixel is in work and rises once its result sits in the output
// register, so a result waiting on out_ready does not hold the input back.
// Reset clears control state and the registers; the noise table is not cleared.
`default_nettype none
`include "assert_macros.svh"
module value_noise_turbulence_top #(
  parameter int GRID_MAX = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vnt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vnt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [vnt_pkg::COORD_W-1:0]     row,
  input  logic [vnt_pkg::COORD_W-1:0]     col,
  input  logic [vnt_pkg::VAL_W-1:0]       noise_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vnt_pkg::GRAY_W-1:0]      gray
);
  import vnt_pkg::*;

  localparam int GW    = $clog2(GRID_MAX + 1);
  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);

  logic [GS_W-1:0]    grid_size;
  logic [ZOOM_W-1:0]  zoom_log2;
  logic [GW-1:0]      g;
  logic               in_acc;
  logic               start;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VAL_W-1:0]   rd_data;
  mac_issue_t         issue;
  logic               done;
  logic [ACC_W-1:0]   sum;
  logic [SHAMT_W-1:0] shamt;
  logic [GRAY_W-1:0]  gray_calc;
  logic [GRAY_W-1:0]  pend_gray;
  logic               pend;
  logic               busy;
  logic               load_out;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RST;
      zoom_log2 <= ZOOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_SIZE: grid_size <= cfg_data;
        REG_ZOOM_LOG2: zoom_log2 <= cfg_data[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid side, clamped to 1..GRID_MAX.
  always_comb begin
    if (grid_size == '0) begin
      g = GW'(1);
    end else if (32'(grid_size) > 32'(GRID_MAX)) begin
      g = GW'(GRID_MAX);
    end else begin
      g = GW'(grid_size);
    end
  end

  // Input acceptance; stores outside the table are dropped.
  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && kind;
  assign wr_en    = in_acc && !kind && (32'(row) < 32'(GRID_MAX)) && (32'(col) < 32'(GRID_MAX));
  assign wr_addr  = AW'(32'(row) * 32'(GRID_MAX) + 32'(col));

  vnt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (noise_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  vnt_seq #(
    .GRID_MAX (GRID_MAX)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .x_in    (row),
    .y_in    (col),
    .g       (g),
    .k       (zoom_log2),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .issue   (issue)
  );

  vnt_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .rd_data (rd_data),
    .done    (done),
    .sum     (sum)
  );

  // Scale the octave sum down to a gray level.
  assign shamt     = {1'b0, zoom_log2, 1'b0} + GRAY_SHIFT_BASE;
  assign gray_calc = GRAY_W'(sum >> shamt);
  assign load_out  = pend && (!out_valid || out_ready);

  // Result hand-off: pending slot, then the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end
      if (done) begin
        pend <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
        busy      <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      pend_gray <= gray_calc;
    end
    if (load_out) begin
      gray <= pend_gray;
    end
  end

  `VNT_ASSERT_IMP(a_done_when_busy, done, busy && !pend, "sum finished with no pixel in work")
  `VNT_ASSERT_IMP(a_pend_busy, pend, busy, "pending result outside a pixel item")

endmodule
`default_nettype wire

/* sv/vnt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module vnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/vnt_seq.sv */
// Octave sequencer: wrapped grid indices, corner addresses and bilinear weights.
`default_nettype none
`include "assert_macros.svh"
module vnt_seq #(
  parameter int GRID_MAX = 128,
  localparam int RW = $clog2(GRID_MAX),
  localparam int GW = $clog2(GRID_MAX + 1),
  localparam int AW = $clog2(GRID_MAX * GRID_MAX)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [vnt_pkg::COORD_W-1:0]  x_in,
  input  logic [vnt_pkg::COORD_W-1:0]  y_in,
  input  logic [GW-1:0]                g,
  input  logic [vnt_pkg::ZOOM_W-1:0]   k,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  output vnt_pkg::mac_issue_t          issue
);
  import vnt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PRE, S_RUN} state_t;

  state_t              state;
  logic [ZOOM_W-1:0]   j;
  logic [ZOOM_W-1:0]   jm1;
  logic [RW-1:0]       rx;
  logic [RW-1:0]       ry;
  logic [RW-1:0]       rx_step;
  logic [RW-1:0]       ry_step;
  logic [RW-1:0]       x2;
  logic [RW-1:0]       y2;
  logic [RW-1:0]       xs;
  logic [RW-1:0]       ys;
  logic [1:0]          corner;
  logic [COORD_W-1:0]  x;
  logic [COORD_W-1:0]  y;
  logic [7:0]          s;
  logic [COORD_W-1:0]  fx;
  logic [COORD_W-1:0]  fy;
  logic [7:0]          ax;
  logic [7:0]          ay;
  logic [15:0]         wprod;

  // One restoring remainder step: (2r + b) mod g, with r already below g.
  function automatic logic [RW-1:0] mod_step(input logic [RW-1:0] r, input logic b,
                                             input logic [GW-1:0] gg);
    logic [RW:0] t;
    t = {r, b};
    if (32'(t) >= 32'(gg)) begin
      mod_step = RW'(32'(t) - 32'(gg));
    end else begin
      mod_step = RW'(t);
    end
  endfunction

  // Moving to the next finer octave brings in one more coordinate bit.
  assign jm1     = j - 3'd1;
  assign rx_step = mod_step(rx, x[jm1], g);
  assign ry_step = mod_step(ry, y[jm1], g);

  // The neighbour below wraps to the last row or column of the grid.
  assign x2 = (rx == '0) ? RW'(g - GW'(1)) : rx - RW'(1);
  assign y2 = (ry == '0) ? RW'(g - GW'(1)) : ry - RW'(1);
  assign xs = corner[1] ? x2 : rx;
  assign ys = corner[0] ? y2 : ry;

  // Fractions within the current cell and the corner weight.
  always_comb begin
    s     = 8'd1 << j;
    fx    = x & COORD_W'(s - 8'd1);
    fy    = y & COORD_W'(s - 8'd1);
    ax    = corner[1] ? (s - {1'b0, fx}) : {1'b0, fx};
    ay    = corner[0] ? (s - {1'b0, fy}) : {1'b0, fy};
    wprod = ax * ay;
  end

  // Read request and the matching issue record.
  assign rd_en        = (state == S_RUN);
  assign rd_addr      = AW'(32'(xs) * 32'(GRID_MAX) + 32'(ys));
  assign issue.vld    = rd_en;
  assign issue.first  = (j == k) && (corner == 2'd0);
  assign issue.last   = (j == 3'd0) && (corner == 2'd3);
  assign issue.shift  = k - j;
  assign issue.weight = WT_W'(wprod);

  // Octave walk: remainder steps down to the first octave, then four reads per octave.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            x      <= x_in;
            y      <= y_in;
            j      <= 3'd7;
            rx     <= '0;
            ry     <= '0;
            corner <= 2'd0;
            state  <= (k == 3'd7) ? S_RUN : S_PRE;
          end
        end
        S_PRE: begin
          j  <= jm1;
          rx <= rx_step;
          ry <= ry_step;
          if (jm1 == k) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          corner <= corner + 2'd1;
          if (corner == 2'd3) begin
            if (j == 3'd0) begin
              state <= S_IDLE;
            end else begin
              j  <= jm1;
              rx <= rx_step;
              ry <= ry_step;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VNT_ASSERT_IMP(a_rem_in_range, state == S_RUN, (32'(rx) < 32'(g)) && (32'(ry) < 32'(g)), "grid index beyond grid size")
  `VNT_ASSERT_IMP(a_start_idle, start, state == S_IDLE, "pixel started while sequencer busy")

endmodule
`default_nettype wire

/* sv/vnt_mac.sv */
// Multiply-accumulate pipe: corner weight times table sample, shifted into the octave sum.
`default_nettype none
`include "assert_macros.svh"
module vnt_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  vnt_pkg::mac_issue_t         issue,
  input  logic [vnt_pkg::VAL_W-1:0]   rd_data,
  output logic                        done,
  output logic [vnt_pkg::ACC_W-1:0]   sum
);
  import vnt_pkg::*;

  mac_issue_t         iss_d;
  logic               p_vld;
  logic               p_first;
  logic               p_last;
  logic [ZOOM_W-1:0]  p_shift;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc;

  // Control: issue aligned with the read data, then product, then sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_d <= '0;
      p_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      iss_d <= issue;
      p_vld <= iss_d.vld;
      done  <= p_vld && p_last;
    end
  end

  // Datapath: one multiply per cycle, registered before the accumulate.
  always_ff @(posedge clk) begin
    prod    <= PROD_W'(iss_d.weight) * PROD_W'(rd_data);
    p_first <= iss_d.first;
    p_last  <= iss_d.last;
    p_shift <= iss_d.shift;
    if (p_vld) begin
      acc <= (p_first ? '0 : acc) + (ACC_W'(prod) << p_shift);
    end
  end

  assign sum = acc;

  `VNT_ASSERT_NXT(a_done_single, done, !done, "two sums finished back to back")

endmodule
`default_nettype wire

/* verif/turbulence_checker.sv */
// Checker for the value noise turbulence block: predicts every gray level and compares it.
`timescale 1ns / 1ps
module turbulence_checker #(
  parameter int GRID_MAX = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [vnt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vnt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           kind,
  input  logic [vnt_pkg::COORD_W-1:0]    row,
  input  logic [vnt_pkg::COORD_W-1:0]    col,
  input  logic [vnt_pkg::VAL_W-1:0]      noise_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [vnt_pkg::GRAY_W-1:0]     gray,
  input  logic                           drained,
  output int                             pending,
  output int                             fail_count,
  output int                             gray_checked
);
  import vnt_pkg::*;

  // Shadow copy of the noise table and of the two registers.
  logic [VAL_W-1:0]  sample_mem [GRID_MAX][GRID_MAX];
  logic [GS_W-1:0]   grid_reg = GRID_SIZE_RST;
  logic [ZOOM_W-1:0] zoom_reg = ZOOM_RST;

  // Gray levels owed by the block, oldest first.
  logic [GRAY_W-1:0] gray_due [$];

  int errors  = 0;
  int checked = 0;
  bit drain_done = 1'b0;

  task automatic report_fault(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  // Octave sum of bilinear blends, each weighted by its size, on a common denominator.
  function automatic logic [GRAY_W-1:0] predict_gray(input int unsigned px,
                                                      input int unsigned py);
    int unsigned g, s, fx, fy, ax, ay, bx, by;
    int j;
    longint unsigned acc, blend, scaled;
    g = (grid_reg == 0) ? 1 : ((grid_reg > GRID_MAX) ? GRID_MAX : grid_reg);
    acc = 0;
    for (j = zoom_reg; j >= 0; j--) begin
      s  = 1 << j;
      fx = px & (s - 1);
      fy = py & (s - 1);
      ax = (px >> j) % g;
      ay = (py >> j) % g;
      // The lower neighbour wraps to the far edge of the grid.
      bx = (ax == 0) ? g - 1 : ax - 1;
      by = (ay == 0) ? g - 1 : ay - 1;
      blend = fx * fy * sample_mem[ax][ay]
            + fx * (s - fy) * sample_mem[ax][by]
            + (s - fx) * fy * sample_mem[bx][ay]
            + (s - fx) * (s - fy) * sample_mem[bx][by];
      acc += blend << (int'(zoom_reg) - j);
    end
    scaled = acc >> (2 * zoom_reg + 9);
    return scaled[GRAY_W-1:0];
  endfunction

  // Follow all three channels at each edge; outputs are updated once per edge.
  always @(posedge clk) begin
    logic [GRAY_W-1:0] want;
    if (rst) begin
      grid_reg = GRID_SIZE_RST;
      zoom_reg = ZOOM_RST;
      gray_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_SIZE: grid_reg = cfg_data[GS_W-1:0];
          REG_ZOOM_LOG2: zoom_reg = cfg_data[ZOOM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (gray_due.size() == 0) begin
          report_fault($sformatf("gray %0d arrived with no pixel outstanding", gray));
        end else begin
          want = gray_due.pop_front();
          checked++;
          if (gray !== want)
            report_fault($sformatf("gray %0d, predicted %0d", gray, want));
        end
      end
      if (in_valid && in_ready) begin
        if (kind) begin
          gray_due.push_back(predict_gray(row, col));
        end else if (row < GRID_MAX && col < GRID_MAX) begin
          sample_mem[row][col] = noise_value;
        end
      end
      // Anything still owed once the stimulus has drained never arrived.
      if (drained && !drain_done) begin
        drain_done = 1'b1;
        if (gray_due.size() != 0)
          report_fault($sformatf("%0d gray levels never arrived", gray_due.size()));
      end
    end
    pending      <= gray_due.size();
    fail_count   <= errors;
    gray_checked <= checked;
  end

endmodule

/* verif/tb.sv */
// Testbench top for the value noise turbulence block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module tb;
  import vnt_pkg::*;

  localparam int GRID_MAX      = 128;
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 500;
  localparam int MIN_PIXELS    = 60;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  kind        = 1'b0;
  logic [COORD_W-1:0]    row         = '0;
  logic [COORD_W-1:0]    col         = '0;
  logic [VAL_W-1:0]      noise_value = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [GRAY_W-1:0]     gray;
  logic                  drained     = 1'b0;

  int pending;
  int fail_count;
  int gray_checked;

  // Stimulus side: current settings and which table entries hold a sample.
  logic [GS_W-1:0]   cur_grid = GRID_SIZE_RST;
  logic [ZOOM_W-1:0] cur_zoom = ZOOM_RST;
  bit                loaded [GRID_MAX][GRID_MAX];
  bit                calm = 1'b0;

  int items_sent    = 0;
  int pixels_sent   = 0;
  int settings_used = 0;
  int cycles        = 0;

  value_noise_turbulence_top #(
    .GRID_MAX(GRID_MAX)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .row         (row),
    .col         (col),
    .noise_value (noise_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gray        (gray)
  );

  turbulence_checker #(
    .GRID_MAX(GRID_MAX)
  ) gray_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .row          (row),
    .col          (col),
    .noise_value  (noise_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gray         (gray),
    .drained      (drained),
    .pending      (pending),
    .fail_count   (fail_count),
    .gray_checked (gray_checked)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog: a run that has not ended by the limit has hung.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d gray levels owed", cycles, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Idle gaps: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Samples lean towards the extremes of the 0.16 range.
  function automatic logic [VAL_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  // Side of the table that the current grid size puts in use.
  function automatic int unsigned span();
    if (cur_grid == 0) return 1;
    if (cur_grid > GRID_MAX) return GRID_MAX;
    return 32'(cur_grid);
  endfunction

  // Offers one item and returns at the edge that accepts it; valid stays high.
  task automatic put_item(input logic k, input logic [COORD_W-1:0] r,
                          input logic [COORD_W-1:0] c, input logic [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    row         <= r;
    col         <= c;
    noise_value <= v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (k == KIND_PIXEL) pixels_sent++;
  endtask

  task automatic store_sample(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                              input logic [VAL_W-1:0] v);
    loaded[r][c] = 1'b1;
    put_item(KIND_STORE, r, c, v);
  endtask

  task automatic load_missing(input int unsigned r, input int unsigned c);
    if (!loaded[r][c]) store_sample(COORD_W'(r), COORD_W'(c), pick_sample());
  endtask

  // A pixel request, preceded by stores for any table entry it reads that holds nothing yet.
  task automatic ask_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    int unsigned g, ax, ay, bx, by;
    int j;
    g = span();
    for (j = cur_zoom; j >= 0; j--) begin
      ax = (px >> j) % g;
      ay = (py >> j) % g;
      bx = (ax == 0) ? g - 1 : ax - 1;
      by = (ay == 0) ? g - 1 : ay - 1;
      load_missing(ax, ay);
      load_missing(ax, by);
      load_missing(bx, ay);
      load_missing(bx, by);
    end
    put_item(KIND_PIXEL, px, py, VAL_W'($urandom));
  endtask

  // Waits until every gray level is in and the last item has left the block.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [GS_W-1:0] g, input logic [ZOOM_W-1:0] z);
    logic [CFG_DATA_W-1:0] zdata;
    settle();
    write_reg(REG_GRID_SIZE, g);
    // Bits above the zoom field carry noise and must be dropped.
    zdata = CFG_DATA_W'($urandom_range(0, 255));
    zdata[ZOOM_W-1:0] = z;
    write_reg(REG_ZOOM_LOG2, zdata);
    // A write to an undecoded index must leave both registers alone.
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                CFG_DATA_W'($urandom_range(0, 255)));
    cur_grid = g;
    cur_zoom = z;
    settings_used++;
  endtask

  // Receiver: random stalls, and one long hold-off that backs the block up.
  initial begin : sink
    int gap;
    int taken;
    taken = 0;
    @(negedge rst);
    forever begin
      gap = (taken == HOLD_AT) ? HOLD_CYCLES : pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int base;
    int phase;
    int grid_pick;
    int waited;
    int steps;
    int n;
    int unsigned wx;
    int unsigned wy;
    logic [GS_W-1:0]   g;
    logic [ZOOM_W-1:0] z;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Two by two grid at the deepest zoom: all-ones samples give gray level 254.
    set_mode(8'd2, 3'd7);
    store_sample(0, 0, 16'hFFFF);
    store_sample(0, 1, 16'hFFFF);
    store_sample(1, 0, 16'hFFFF);
    store_sample(1, 1, 16'hFFFF);
    ask_pixel(127, 127);
    ask_pixel(0, 0);

    // All-zero samples give black.
    store_sample(0, 0, 16'h0000);
    store_sample(0, 1, 16'h0000);
    store_sample(1, 0, 16'h0000);
    store_sample(1, 1, 16'h0000);
    ask_pixel(127, 0);

    // Alternating bit patterns in the samples.
    store_sample(0, 0, 16'h5555);
    store_sample(0, 1, 16'hAAAA);
    store_sample(1, 0, 16'h8001);
    store_sample(1, 1, 16'h7FFE);
    ask_pixel(0, 127);
    ask_pixel(85, 42);

    // Grid size zero behaves as a single entry.
    set_mode(8'd0, 3'd0);
    ask_pixel(127, 127);

    // Grid size above the table is clipped; the origin wraps to the far corner.
    set_mode(8'd255, 3'd0);
    ask_pixel(0, 0);

    // Random phases, the first few at the reset values and the register extremes.
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS || pixels_sent < MIN_PIXELS) begin
      case (phase)
        0: begin g = GRID_SIZE_RST; z = ZOOM_RST; end
        1: begin g = 8'd1;          z = 3'd7;     end
        2: begin g = 8'd128;        z = 3'd7;     end
        3: begin g = 8'd128;        z = 3'd0;     end
        default: begin
          grid_pick = $urandom_range(0, 99);
          if (grid_pick < 50)      g = GS_W'($urandom_range(1, 16));
          else if (grid_pick < 65) g = GS_W'($urandom_range(17, 128));
          else if (grid_pick < 75) g = 8'd128;
          else if (grid_pick < 85) g = 8'd0;
          else                     g = GS_W'($urandom_range(129, 255));
          z = ZOOM_W'($urandom_range(0, 7));
        end
      endcase
      set_mode(g, z);
      calm = ($urandom_range(0, 3) == 0);
      // Pixels of one phase fall in a small window, so the samples they need stay few.
      wx    = $urandom_range(0, 127);
      wy    = $urandom_range(0, 127);
      steps = $urandom_range(20, 60);
      for (n = 0; n < steps && (items_sent - base < RANDOM_ITEMS || pixels_sent < MIN_PIXELS);
           n++) begin
        if ($urandom_range(0, 99) < 65) begin
          ask_pixel(COORD_W'(wx + $urandom_range(0, 3)), COORD_W'(wy + $urandom_range(0, 3)));
        end else if ($urandom_range(0, 3) != 0) begin
          // Overwrite an entry inside the grid in use.
          store_sample(COORD_W'($urandom_range(0, span() - 1)),
                       COORD_W'($urandom_range(0, span() - 1)), pick_sample());
        end else begin
          store_sample(COORD_W'($urandom_range(0, 127)), COORD_W'($urandom_range(0, 127)),
                       pick_sample());
        end
      end
      phase++;
    end

    // Drain, then give the block time to show any stray result.
    calm = 1'b0;
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Drove %0d items (%0d pixel requests) over %0d register settings; %0d grays checked.",
             items_sent, pixels_sent, settings_used, gray_checked);
    $display("Grid sizes 0, 1, 2, 128 and 255 were used, with a random zoom per phase, and one long output stall.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/vnt_pkg.sv
sv/vnt_ram.sv
sv/vnt_seq.sv
sv/vnt_mac.sv
sv/value_noise_turbulence_top.sv
verif/turbulence_checker.sv
verif/tb.sv
